@@ rtl/core/bls_pkg.sv @@
// ----------------------------------------------------------------------------
// Bounded LIFO stack package
// Command and status codes, and the control word shared by the stack cells.
// ----------------------------------------------------------------------------
`default_nettype none

package bls_pkg;

	// Command codes carried by an input beat.
	localparam logic [1:0] CMD_PUSH = 2'd0;
	localparam logic [1:0] CMD_POP  = 2'd1;
	localparam logic [1:0] CMD_PEEK = 2'd2;

	// Status codes carried by a result beat.
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_OVERFLOW  = 2'd1;
	localparam logic [1:0] ST_UNDERFLOW = 2'd2;
	localparam logic [1:0] ST_BADPOS    = 2'd3;

	// Control word broadcast to every cell of the chain.
	typedef struct packed {
		logic push;   // every entry moves one cell away from the top
		logic pop;    // every entry moves one cell towards the top
		logic load;   // read chain takes a copy of the entries
		logic shift;  // read chain moves one cell towards the top
	} cell_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/core/bls_cell.sv @@
// ----------------------------------------------------------------------------
// Bounded LIFO stack cell
// Holds one stack entry and one read-chain word, each handed on to the
// neighbouring cells under the shared control word.
// ----------------------------------------------------------------------------
`default_nettype none

module bls_cell #(
	parameter int DATA_WIDTH = 32
) (
	input  wire                      clk,
	input  wire bls_pkg::cell_ctrl_t ctrl,
	input  wire [DATA_WIDTH-1:0]     entry_above,
	input  wire [DATA_WIDTH-1:0]     entry_below,
	input  wire [DATA_WIDTH-1:0]     rd_below,
	output logic [DATA_WIDTH-1:0]    entry,
	output logic [DATA_WIDTH-1:0]    rd
);
	import bls_pkg::*;

	logic [DATA_WIDTH-1:0] entry_q;
	logic [DATA_WIDTH-1:0] rd_q;

	// The entry moves down on a push and up on a pop.
	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			entry_q <= entry_above;
		end else if (ctrl.pop) begin
			entry_q <= entry_below;
		end
	end

	// The read chain is loaded from the entries, then walks towards the top.
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			rd_q <= entry_q;
		end else if (ctrl.shift) begin
			rd_q <= rd_below;
		end
	end

	assign entry = entry_q;
	assign rd    = rd_q;

endmodule

`default_nettype wire

@@ rtl/core/bounded_lifo_stack.sv @@
// ----------------------------------------------------------------------------
// Bounded LIFO stack
// Push, pop and peek on a stack held in a chain of cells, with a
// configurable fill limit and full and empty flags on every result.
// ----------------------------------------------------------------------------
//
// Channel  Direction  Handshake             Payload
// in       input      in_valid / in_stall   cmd, push_value, position
// out      output     out_valid / out_stall read_data, status, is_full, is_empty
// cfg      input      cfg_valid / cfg_ready cfg_data (stack_limit)
//
// Push, pop, an unused command and a rejected peek give their result straight
// from the idle state. A valid peek of position p loads the read chain from
// the cells, which then walks p - 1 cells towards the top in the peek state.
// One beat is in work at a time; a new beat is taken while the previous
// result is being handed on, so a stalled output holds back the input.
// After reset the stack is empty and the limit is min(128, DEPTH).
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_lifo_stack #(
	parameter int DEPTH      = 128,
	parameter int DATA_WIDTH = 32
) (
	input  wire                 clk,
	input  wire                 arst_n,
	// Configuration
	input  wire                 cfg_valid,
	output logic                cfg_ready,
	input  wire  [7:0]          cfg_data,
	// Input channel
	input  wire                 in_valid,
	output logic                in_stall,
	input  wire  [1:0]          cmd,
	input  wire  signed [31:0]  push_value,
	input  wire  [7:0]          position,
	// Output channel
	output logic                out_valid,
	input  wire                 out_stall,
	output logic signed [31:0]  read_data,
	output logic [1:0]          status,
	output logic                is_full,
	output logic                is_empty
);
	import bls_pkg::*;

	localparam int CW      = $clog2(DEPTH + 1);
	localparam int CMPW    = (CW > 8) ? CW : 8;
	localparam int RST_LIM = (DEPTH < 128) ? DEPTH : 128;

	typedef enum logic {
		S_IDLE,
		S_PEEK
	} state_t;

	state_t                state_q;
	logic [CW-1:0]         count_q;
	logic [CW-1:0]         lim_q;
	logic [7:0]            remain_q;
	logic                  out_valid_q;
	logic [31:0]           read_data_q;
	logic [1:0]            status_q;
	logic                  is_full_q;
	logic                  is_empty_q;

	cell_ctrl_t            ctrl;
	logic [DATA_WIDTH-1:0] entry_w [DEPTH];
	logic [DATA_WIDTH-1:0] rd_w [DEPTH];

	logic                  out_free;
	logic                  in_accept;
	logic                  push_ok;
	logic                  pop_ok;
	logic                  peek_ok;
	logic [CW-1:0]         count_next;
	logic [CW-1:0]         new_lim;
	logic [CMPW-1:0]       cfg_ext;
	logic [DATA_WIDTH-1:0] push_word;
	logic [DATA_WIDTH+31:0] push_ext;
	logic [DATA_WIDTH+31:0] pop_ext;
	logic [DATA_WIDTH+31:0] peek_ext;
	logic [DATA_WIDTH+31:0] err_ext;

	// Handshakes: one beat in work at a time.
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = !((state_q == S_IDLE) && out_free);
	assign in_accept = in_valid && !in_stall;

	// Word conversions between the 32-bit ports and the stored width.
	assign push_ext  = {{DATA_WIDTH{1'b0}}, push_value};
	assign push_word = push_ext[DATA_WIDTH-1:0];
	assign pop_ext   = {32'b0, entry_w[0]};
	assign peek_ext  = {32'b0, rd_w[0]};
	assign err_ext   = {32'b0, {DATA_WIDTH{1'b1}}};

	// Limit clamped to 1..DEPTH as it is written.
	always_comb begin
		cfg_ext = CMPW'(cfg_data);
		if (cfg_data == 8'd0) begin
			new_lim = CW'(1);
		end else if (cfg_ext > CMPW'(DEPTH)) begin
			new_lim = CW'(DEPTH);
		end else begin
			new_lim = CW'(cfg_ext);
		end
	end

	// Command decode and next count.
	always_comb begin
		push_ok = (cmd == CMD_PUSH) && (count_q < lim_q);
		pop_ok  = (cmd == CMD_POP) && (count_q != '0);
		peek_ok = (cmd == CMD_PEEK) && (position != 8'd0)
			&& (CMPW'(position) <= CMPW'(count_q));
		count_next = count_q;
		if (push_ok) begin
			count_next = count_q + CW'(1);
		end else if (pop_ok) begin
			count_next = count_q - CW'(1);
		end
		ctrl.push  = in_accept && push_ok;
		ctrl.pop   = in_accept && pop_ok;
		ctrl.load  = in_accept && peek_ok;
		ctrl.shift = (state_q == S_PEEK) && (remain_q != 8'd0);
	end

	// Chain of cells, the top of the stack in the first cell.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] above;
		logic [DATA_WIDTH-1:0] below;
		logic [DATA_WIDTH-1:0] rd_next;
		if (i == 0) begin : g_top
			assign above = push_word;
		end else begin : g_mid
			assign above = entry_w[i-1];
		end
		if (i == DEPTH - 1) begin : g_end
			assign below   = '0;
			assign rd_next = '0;
		end else begin : g_link
			assign below   = entry_w[i+1];
			assign rd_next = rd_w[i+1];
		end
		bls_cell #(
			.DATA_WIDTH (DATA_WIDTH)
		) u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.entry_above (above),
			.entry_below (below),
			.rd_below    (rd_next),
			.entry       (entry_w[i]),
			.rd          (rd_w[i])
		);
	end

	// Sequencer, count, limit and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			lim_q       <= CW'(RST_LIM);
			remain_q    <= 8'd0;
			out_valid_q <= 1'b0;
			read_data_q <= '0;
			status_q    <= ST_OK;
			is_full_q   <= 1'b0;
			is_empty_q  <= 1'b1;
		end else begin
			if (cfg_valid) begin
				lim_q <= new_lim;
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						count_q <= count_next;
						if (peek_ok) begin
							state_q  <= S_PEEK;
							remain_q <= position - 8'd1;
						end else begin
							out_valid_q <= 1'b1;
							is_full_q   <= (count_next >= lim_q);
							is_empty_q  <= (count_next == '0);
							read_data_q <= err_ext[31:0];
							status_q    <= ST_OK;
							case (cmd)
								CMD_PUSH: begin
									if (!push_ok) begin
										status_q <= ST_OVERFLOW;
									end
								end
								CMD_POP: begin
									if (pop_ok) begin
										read_data_q <= pop_ext[31:0];
									end else begin
										status_q <= ST_UNDERFLOW;
									end
								end
								CMD_PEEK: begin
									status_q <= ST_BADPOS;
								end
								default: begin
									status_q <= ST_OK;
								end
							endcase
						end
					end
				end
				S_PEEK: begin
					if (remain_q != 8'd0) begin
						remain_q <= remain_q - 8'd1;
					end else if (out_free) begin
						state_q     <= S_IDLE;
						out_valid_q <= 1'b1;
						read_data_q <= peek_ext[31:0];
						status_q    <= ST_OK;
						is_full_q   <= (count_q >= lim_q);
						is_empty_q  <= (count_q == '0);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = read_data_q;
	assign status    = status_q;
	assign is_full   = is_full_q;
	assign is_empty  = is_empty_q;

	// The count never runs past the number of cells.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CMPW'(count_q) <= CMPW'(DEPTH))
		else $error("entry count beyond depth");

	// No beat is taken while a peek walks the read chain.
	a_peek_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PEEK) |-> !in_accept)
		else $error("beat accepted during peek");

	// A push below the limit grows the stack by one entry.
	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && (cmd == CMD_PUSH) && (count_q < lim_q))
		|=> (count_q == $past(count_q) + CW'(1)))
		else $error("push did not grow the stack");

endmodule

`default_nettype wire

@@ tb/bounded_lifo_stack_test.sv @@
// ----------------------------------------------------------------------------
// Bounded LIFO stack testbench
// Drives push, pop, peek and unused commands through the stack with random
// gaps and output stalls, across a range of fill limits. Every result beat is
// compared with a shadow copy of the stack kept inside the bench.
// ----------------------------------------------------------------------------

module bounded_lifo_stack_test;

	import bls_pkg::*;

	localparam int STACK_DEPTH = 128;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int IDLE_LIMIT = 2000;
	localparam int PRINT_LIMIT = 30;

	typedef struct {
		logic [31:0] data;
		logic [1:0]  code;
		logic        full;
		logic        empty;
	} stack_result_t;

	// Shadow of the stack: predicts each result and holds those still to come.
	class lifo_shadow;
		bit [7:0]      limit_reg;
		int unsigned   fill;
		logic [31:0]   words [STACK_DEPTH];
		stack_result_t due_results [$];
		int            errors;
		int            checked;
		int            op_seen [4];
		int            status_seen [4];
		int            deepest;
		int            over_limit_pushes;

		function new();
			limit_reg = 8'd128;
			fill = 0;
			errors = 0;
			checked = 0;
			deepest = 0;
			over_limit_pushes = 0;
			foreach (op_seen[i]) op_seen[i] = 0;
			foreach (status_seen[i]) status_seen[i] = 0;
		endfunction

		// A limit of zero behaves as one, and anything above the depth as the depth.
		function int unsigned effective_limit();
			if (limit_reg == 0)
				return 1;
			if (limit_reg > STACK_DEPTH)
				return STACK_DEPTH;
			return 32'(limit_reg);
		endfunction

		function void set_limit(bit [7:0] value);
			limit_reg = value;
		endfunction

		function void apply_operation(logic [1:0] op, logic [31:0] value, logic [7:0] depth_pos);
			stack_result_t res;
			int unsigned   lim;
			lim = effective_limit();
			res.data = '1;
			res.code = ST_OK;
			case (op)
				CMD_PUSH: begin
					if (fill > lim)
						over_limit_pushes++;
					if (fill >= lim) begin
						res.code = ST_OVERFLOW;
					end else begin
						words[fill] = value;
						fill++;
					end
				end
				CMD_POP: begin
					if (fill == 0) begin
						res.code = ST_UNDERFLOW;
					end else begin
						fill--;
						res.data = words[fill];
					end
				end
				CMD_PEEK: begin
					if (depth_pos == 0 || depth_pos > fill)
						res.code = ST_BADPOS;
					else
						res.data = words[fill - depth_pos];
				end
				default: begin
				end
			endcase
			res.full = (fill >= lim);
			res.empty = (fill == 0);
			if (fill > deepest)
				deepest = fill;
			op_seen[op]++;
			status_seen[res.code]++;
			due_results.push_back(res);
		endfunction

		task report_mismatch(input string what);
			errors++;
			if (errors <= PRINT_LIMIT)
				$display("MISMATCH: %s", what);
		endtask

		task check_result(input logic [31:0] data, input logic [1:0] code,
				input logic full, input logic empty);
			stack_result_t want;
			if (due_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result beat, data %h status %0d",
					data, code));
				return;
			end
			want = due_results.pop_front();
			checked++;
			if (data !== want.data || code !== want.code || full !== want.full
					|| empty !== want.empty)
				report_mismatch($sformatf(
					"result %0d: got data %h status %0d full %b empty %b, want %h %0d %b %b",
					checked, data, code, full, empty,
					want.data, want.code, want.full, want.empty));
		endtask
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [7:0]         cfg_data = 8'd0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         cmd = CMD_PUSH;
	logic signed [31:0] push_value = '0;
	logic [7:0]         position = 8'd0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [31:0] read_data;
	logic [1:0]         status;
	logic               is_full;
	logic               is_empty;

	lifo_shadow shadow;
	bit         gaps_on = 1'b1;
	logic       stall_on = 1'b1;
	int         stall_left = 0;
	int         idle_cycles = 0;

	bounded_lifo_stack i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cmd        (cmd),
		.push_value (push_value),
		.position   (position),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.read_data  (read_data),
		.status     (status),
		.is_full    (is_full),
		.is_empty   (is_empty)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Output side: random bursts of stall while enabled.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (stall_on && $urandom_range(0, 99) < 30) begin
			out_stall <= 1'b1;
			stall_left <= pick_gap();
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Every result beat taken by the output side is checked.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			shadow.check_result(read_data, status, is_full, is_empty);
	end

	// Ends the run if no channel moves a beat for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == IDLE_LIMIT) begin
			$display("Timed out: no beat moved for %0d cycles", IDLE_LIMIT);
			$display("RESULT: ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Offers one command beat and holds it until taken, then maybe leaves a gap.
	task automatic send_item(input logic [1:0] op, input logic [31:0] value,
			input logic [7:0] depth_pos);
		int unsigned gap;
		cmd <= op;
		push_value <= value;
		position <= depth_pos;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		shadow.apply_operation(op, value, depth_pos);
		gap = gaps_on ? pick_gap() : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Holds the input back until every predicted result has been seen.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (shadow.due_results.size() != 0)
			@(posedge clk);
	endtask

	// The limit is only changed once the stack has gone quiet.
	task automatic write_limit(input logic [7:0] value);
		drain_results();
		repeat (2) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		shadow.set_limit(value);
	endtask

	// One random phase at a given limit; push_pct steers the fill level.
	task automatic run_phase(input logic [7:0] limit_value, input int unsigned push_pct,
			input int unsigned beats, input bit quiet);
		int unsigned k;
		int unsigned r;
		logic [1:0]  op;
		logic [31:0] value;
		logic [7:0]  depth_pos;
		write_limit(limit_value);
		gaps_on = !quiet;
		stall_on <= !quiet;
		for (k = 0; k < beats; k++) begin
			if (k == beats / 2)
				drain_results();
			value = $urandom;
			depth_pos = 8'($urandom_range(0, 255));
			r = $urandom_range(0, 99);
			if (r < push_pct) begin
				op = CMD_PUSH;
				case ($urandom_range(0, 15))
					0: value = 32'h8000_0000;
					1: value = 32'h7fff_ffff;
					2: value = 32'h0000_0000;
					3: value = 32'hffff_ffff;
					default: begin
					end
				endcase
			end else begin
				r = $urandom_range(0, 99);
				if (r < 46)
					op = CMD_POP;
				else if (r < 95)
					op = CMD_PEEK;
				else
					op = CMD_UNUSED;
			end
			// Peeks mostly land inside the stack, with some at each edge.
			if (op == CMD_PEEK) begin
				r = $urandom_range(0, 9);
				if (r == 0)
					depth_pos = 8'd0;
				else if (r == 1)
					depth_pos = 8'(shadow.fill + 1);
				else if (r > 2)
					depth_pos = (shadow.fill > 0) ?
						8'($urandom_range(1, shadow.fill)) : 8'd1;
			end
			send_item(op, value, depth_pos);
		end
	endtask

	initial begin
		shadow = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty stack at the reset limit.
		send_item(CMD_POP, 32'h0, 8'd0);
		send_item(CMD_PEEK, 32'h0, 8'd1);
		send_item(CMD_PEEK, 32'h0, 8'd0);
		send_item(CMD_UNUSED, 32'hffff_ffff, 8'hff);
		// Extreme words, then peeks at and just past each end.
		send_item(CMD_PUSH, 32'h7fff_ffff, 8'd0);
		send_item(CMD_PUSH, 32'h8000_0000, 8'd0);
		send_item(CMD_PUSH, 32'h0000_0000, 8'hff);
		send_item(CMD_PUSH, 32'hffff_ffff, 8'd0);
		send_item(CMD_PUSH, 32'h5a5a_a5a5, 8'd0);
		send_item(CMD_PEEK, 32'h0, 8'd1);
		send_item(CMD_PEEK, 32'h0, 8'd5);
		send_item(CMD_PEEK, 32'h0, 8'd6);
		send_item(CMD_PEEK, 32'h0, 8'd0);
		send_item(CMD_PEEK, 32'h0, 8'd255);
		send_item(CMD_PEEK, 32'h0, 8'd128);
		send_item(CMD_UNUSED, 32'h0, 8'd0);
		// Empty it again and pop once more than it holds.
		repeat (6) send_item(CMD_POP, 32'h0, 8'd0);
		// Smallest limit: the second push overflows.
		write_limit(8'd1);
		send_item(CMD_PUSH, 32'h1234_5678, 8'd0);
		send_item(CMD_PUSH, 32'hdead_beef, 8'd0);
		send_item(CMD_PEEK, 32'h0, 8'd1);
		send_item(CMD_POP, 32'h0, 8'd0);

		// Random phases; the limit of ten lands while the stack is nearly full.
		run_phase(8'd0, 50, 150, 1'b0);
		run_phase(8'd3, 55, 150, 1'b1);
		run_phase(8'd255, 75, 300, 1'b0);
		run_phase(8'd128, 40, 200, 1'b0);
		run_phase(8'd10, 30, 250, 1'b1);
		run_phase(8'd1, 50, 100, 1'b0);
		run_phase(8'($urandom_range(1, 128)), 60, 200, 1'b0);
		run_phase(8'($urandom_range(0, 255)), 50, 200, 1'b1);
		run_phase(8'd64, 55, 200, 1'b0);

		drain_results();
		repeat (10) @(posedge clk);

		$display("Checked %0d results: %0d push, %0d pop, %0d peek, %0d unused; deepest fill %0d",
			shadow.checked, shadow.op_seen[CMD_PUSH], shadow.op_seen[CMD_POP],
			shadow.op_seen[CMD_PEEK], shadow.op_seen[CMD_UNUSED], shadow.deepest);
		$display("Statuses: %0d ok, %0d overflow, %0d underflow, %0d bad position; %0d %s",
			shadow.status_seen[ST_OK], shadow.status_seen[ST_OVERFLOW],
			shadow.status_seen[ST_UNDERFLOW], shadow.status_seen[ST_BADPOS],
			shadow.over_limit_pushes, "pushes above a lowered limit");
		if (shadow.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
